// ===== design/bgrc_pkg.sv =====
// bgrc_pkg: shared types and constants for the greedy rectangle cover core
// cell codes, stream field widths, memory control and result structures
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bgrc_pkg;

  // fixed field widths of the stream payloads
  localparam int COL_W       = 5;
  localparam int ROW_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // cell codes held in the grid memory
  localparam logic [1:0] CELL_EMPTY   = 2'd0;
  localparam logic [1:0] CELL_FILLED  = 2'd1;
  localparam logic [1:0] CELL_COVERED = 2'd2;

  // request kinds carried on in_tuser
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // grid memory access control
  typedef struct packed {
    logic       en;
    logic       we;
    logic [1:0] wdata;
  } mem_ctl_t;

  // one rectangle result
  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bgrc_grid_mem.sv =====
// bgrc_grid_mem: single-port cell grid memory, two bits per cell
// read data registered; uses bgrc_pkg for the control structure
`timescale 1ns / 1ps
`default_nettype none

module bgrc_grid_mem #(
  parameter int DEPTH = 1008,
  parameter int AW    = 10
) (
  input  wire                 clk,
  input  bgrc_pkg::mem_ctl_t  ctl,
  input  wire logic [AW-1:0]  addr,
  output logic [1:0]          rdata
);

  logic [1:0] mem_r [DEPTH];
  logic [1:0] rdata_r;

  // one access per cycle: write or registered read
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem_r[addr] <= ctl.wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bgrc_seq.sv =====
// bgrc_seq: sequencer for load, scan and rectangle growth over the grid memory
// one shared address unit (col * rows + row) drives every access but the clearing pass; uses bgrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bgrc_seq #(
  parameter int GRID_COLS = 28,
  parameter int GRID_ROWS = 36
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire                            in_action,
  input  wire logic [bgrc_pkg::COL_W-1:0] in_col,
  input  wire logic [bgrc_pkg::ROW_W-1:0] in_row,
  input  wire                            in_on,
  output bgrc_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(GRID_COLS*GRID_ROWS)-1:0] mem_addr,
  input  wire logic [1:0]                mem_rdata,
  output bgrc_pkg::result_t              res,
  output logic                           res_valid,
  input  wire                            res_taken
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_COLS + 1);
  localparam int RW    = $clog2(GRID_ROWS + 1);

  localparam logic [CW-1:0] COLS_C    = CW'(GRID_COLS);
  localparam logic [RW-1:0] ROWS_C    = RW'(GRID_ROWS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_ROWS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_SCAN   = 14'b00000000000100,
    ST_START  = 14'b00000000001000,
    ST_ROUND  = 14'b00000000010000,
    ST_RTEST  = 14'b00000000100000,
    ST_CTEST  = 14'b00000001000000,
    ST_RMARK  = 14'b00000010000000,
    ST_CMARK  = 14'b00000100000000,
    ST_CRN_RD = 14'b00001000000000,
    ST_CRN_WR = 14'b00010000000000,
    ST_STEP   = 14'b00100000000000,
    ST_FIN    = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CW-1:0]     ptc_r, ptc_nxt;
  logic [RW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     qc_r, qc_nxt;
  logic [RW-1:0]     qr_r, qr_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     c0_r, c0_nxt;
  logic [RW-1:0]     r0_r, r0_nxt;
  logic [CW-1:0]     x_r, x_nxt;
  logic [RW-1:0]     y_r, y_nxt;
  logic              xq_r, xq_nxt;
  logic              yq_r, yq_nxt;
  bgrc_pkg::result_t res_r, res_nxt;

  logic          in_accept;
  logic          load_in_range;
  logic [CW-1:0] addr_col;
  logic [RW-1:0] addr_row;
  logic          rd_empty;
  logic          rd_filled;
  logic [CW-1:0] x_step;
  logic [RW-1:0] y_step;
  logic [CW-1:0] width;
  logic [RW-1:0] height;

  assign in_tready     = (state_r == ST_IDLE);
  assign in_accept     = in_tvalid && in_tready;
  assign load_in_range = (32'(in_col) < GRID_COLS) && (32'(in_row) < GRID_ROWS);
  assign rd_empty      = (mem_rdata == bgrc_pkg::CELL_EMPTY);
  assign rd_filled     = (mem_rdata == bgrc_pkg::CELL_FILLED);
  assign x_step        = xq_r ? x_r : x_r + 1'b1;
  assign y_step        = yq_r ? y_r : y_r + 1'b1;
  assign width         = x_r - c0_r;
  assign height        = y_r - r0_r;
  assign res           = res_r;
  assign res_valid     = (state_r == ST_DONE);

  // shared address unit: load coordinates while idle, walk pointer otherwise; clearing uses clr_r
  always_comb begin
    if (state_r == ST_IDLE) begin
      addr_col = CW'(in_col);
      addr_row = RW'(in_row);
    end else begin
      addr_col = ptc_r;
      addr_row = ptr_r;
    end
    if (state_r == ST_CLEAR) begin
      mem_addr = clr_r;
    end else begin
      mem_addr = AW'(addr_col) * AW'(GRID_ROWS) + AW'(addr_row);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ptc_nxt   = ptc_r;
    ptr_nxt   = ptr_r;
    qc_nxt    = qc_r;
    qr_nxt    = qr_r;
    pend_nxt  = pend_r;
    c0_nxt    = c0_r;
    r0_nxt    = r0_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    xq_nxt    = xq_r;
    yq_nxt    = yq_r;
    res_nxt   = res_r;
    mem_ctl   = '0;

    case (state_r)
      // wipe the grid to empty after reset
      ST_CLEAR: begin
        mem_ctl.en    = 1'b1;
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = bgrc_pkg::CELL_EMPTY;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // take loads in place, start a scan on a rectangle request
      ST_IDLE: begin
        if (in_accept) begin
          if (in_action == bgrc_pkg::ACT_REQUEST) begin
            state_nxt = ST_SCAN;
            ptc_nxt   = '0;
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
          end else if (load_in_range) begin
            mem_ctl.en    = 1'b1;
            mem_ctl.we    = 1'b1;
            mem_ctl.wdata = in_on ? bgrc_pkg::CELL_FILLED : bgrc_pkg::CELL_EMPTY;
          end
        end
      end

      // column-major search for the first filled cell, one read a cycle
      ST_SCAN: begin
        if (pend_r && rd_filled) begin
          c0_nxt    = qc_r;
          r0_nxt    = qr_r;
          ptc_nxt   = qc_r;
          ptr_nxt   = qr_r;
          pend_nxt  = 1'b0;
          state_nxt = ST_START;
        end else if (ptc_r < COLS_C) begin
          mem_ctl.en = 1'b1;
          qc_nxt     = ptc_r;
          qr_nxt     = ptr_r;
          pend_nxt   = 1'b1;
          if (ptr_r == LAST_ROW) begin
            ptr_nxt = '0;
            ptc_nxt = ptc_r + 1'b1;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else begin
          pend_nxt  = 1'b0;
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      // cover the start cell and set up the growth bounds
      ST_START: begin
        mem_ctl.en    = 1'b1;
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = bgrc_pkg::CELL_COVERED;
        x_nxt         = c0_r + 1'b1;
        y_nxt         = r0_r + 1'b1;
        xq_nxt        = ((c0_r + 1'b1) == COLS_C);
        yq_nxt        = ((r0_r + 1'b1) == ROWS_C);
        state_nxt     = ST_ROUND;
      end

      // loop test of one growth round
      ST_ROUND: begin
        if ((!xq_r || !yq_r) && (x_r > c0_r) && (y_r > r0_r)) begin
          pend_nxt = 1'b0;
          if (!yq_r) begin
            state_nxt = ST_RTEST;
            ptc_nxt   = c0_r;
            ptr_nxt   = y_r;
          end else begin
            state_nxt = ST_CTEST;
            ptc_nxt   = x_r;
            ptr_nxt   = r0_r;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // row edge test: cells c0..x-1 of row y, stop on an empty cell
      ST_RTEST: begin
        if ((pend_r && rd_empty) || !(ptc_r < x_r)) begin
          pend_nxt = 1'b0;
          if (pend_r && rd_empty) begin
            yq_nxt = 1'b1;
            y_nxt  = y_r - 1'b1;
          end
          if (!xq_r) begin
            state_nxt = ST_CTEST;
            ptc_nxt   = x_r;
            ptr_nxt   = r0_r;
          end else if (!(pend_r && rd_empty)) begin
            state_nxt = ST_RMARK;
            ptc_nxt   = c0_r;
            ptr_nxt   = y_r;
          end else begin
            state_nxt = ST_STEP;
          end
        end else begin
          mem_ctl.en = 1'b1;
          ptc_nxt    = ptc_r + 1'b1;
          pend_nxt   = 1'b1;
        end
      end

      // column edge test: cells r0..y-1 of column x, stop on an empty cell
      ST_CTEST: begin
        if ((pend_r && rd_empty) || !(ptr_r < y_r)) begin
          pend_nxt = 1'b0;
          if (pend_r && rd_empty) begin
            xq_nxt = 1'b1;
            x_nxt  = x_r - 1'b1;
          end
          if (!yq_r) begin
            state_nxt = ST_RMARK;
            ptc_nxt   = c0_r;
            ptr_nxt   = y_r;
          end else if (!(pend_r && rd_empty)) begin
            state_nxt = ST_CMARK;
            ptc_nxt   = x_r;
            ptr_nxt   = r0_r;
          end else begin
            state_nxt = ST_STEP;
          end
        end else begin
          mem_ctl.en = 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
          pend_nxt   = 1'b1;
        end
      end

      // cover the accepted row edge
      ST_RMARK: begin
        if (ptc_r < x_r) begin
          mem_ctl.en    = 1'b1;
          mem_ctl.we    = 1'b1;
          mem_ctl.wdata = bgrc_pkg::CELL_COVERED;
          ptc_nxt       = ptc_r + 1'b1;
        end else if (!xq_r) begin
          state_nxt = ST_CMARK;
          ptc_nxt   = x_r;
          ptr_nxt   = r0_r;
        end else begin
          state_nxt = ST_STEP;
        end
      end

      // cover the accepted column edge
      ST_CMARK: begin
        if (ptr_r < y_r) begin
          mem_ctl.en    = 1'b1;
          mem_ctl.we    = 1'b1;
          mem_ctl.wdata = bgrc_pkg::CELL_COVERED;
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!yq_r) begin
          state_nxt = ST_CRN_RD;
          ptc_nxt   = x_r;
          ptr_nxt   = y_r;
        end else begin
          state_nxt = ST_STEP;
        end
      end

      // diagonal corner when both edges passed
      ST_CRN_RD: begin
        mem_ctl.en = 1'b1;
        state_nxt  = ST_CRN_WR;
      end

      ST_CRN_WR: begin
        if (!rd_empty) begin
          mem_ctl.en    = 1'b1;
          mem_ctl.we    = 1'b1;
          mem_ctl.wdata = bgrc_pkg::CELL_COVERED;
        end
        state_nxt = ST_STEP;
      end

      // advance the open sides, close a side at the grid border
      ST_STEP: begin
        x_nxt     = x_step;
        y_nxt     = y_step;
        xq_nxt    = xq_r || (x_step == COLS_C);
        yq_nxt    = yq_r || (y_step == ROWS_C);
        state_nxt = ST_ROUND;
      end

      // build the result, zero size reports not-found
      ST_FIN: begin
        if ((width != '0) && (height != '0)) begin
          res_nxt.found = 1'b1;
          res_nxt.col   = bgrc_pkg::COL_W'(c0_r);
          res_nxt.row   = bgrc_pkg::ROW_W'(r0_r);
          res_nxt.cols  = bgrc_pkg::COL_W'(width);
          res_nxt.rows  = bgrc_pkg::ROW_W'(height);
        end else begin
          res_nxt = '0;
        end
        state_nxt = ST_DONE;
      end

      // wait for the output register to take the result
      ST_DONE: begin
        if (res_taken) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptc_r <= ptc_nxt;
    ptr_r <= ptr_nxt;
    qc_r  <= qc_nxt;
    qr_r  <= qr_nxt;
    c0_r  <= c0_nxt;
    r0_r  <= r0_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    xq_r  <= xq_nxt;
    yq_r  <= yq_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== design/bitmap_greedy_rectangle_cover_core.sv =====
// Greedy rectangle cover core.
// in_*: one request per item. in_tuser = 0 loads one pixel into the cell grid,
//   in_tuser = 1 asks for the next rectangle. out_*: one result per rectangle
//   request, none per load.
// Loads are taken back to back while idle.
// A rectangle request scans the cells column by column up to and including
//   the first filled cell, then grows the rectangle round by round, testing
//   and covering edge cells. Every cell access goes through the single port
//   of the grid memory. With no filled cell the result reports not-found.
// in_tready is low while a request is worked on; the result lands in an
//   output register, and loads are taken again while it waits there.
// After reset the grid is cleared to empty one cell a cycle, all
//   GRID_COLS*GRID_ROWS cells (1008 at the defaults); in_tready stays low
//   until the clearing pass ends.
// If the receiver stalls, the result holds in the output register and the
//   next request waits at the end of its work until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_greedy_rectangle_cover_core #(
  parameter int GRID_COLS = 28,
  parameter int GRID_ROWS = 36
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  // pixel_col[4:0], pixel_row[10:5], pixel_on[11], zero[15:12]
  input  wire logic [bgrc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  // rect_col[4:0], rect_row[10:5], rect_cols[15:11], rect_rows[21:16], zero[23:22]
  output logic [bgrc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // found[0]
  output logic                                    out_tuser
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);

  bgrc_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [1:0]         mem_rdata;
  bgrc_pkg::result_t  res;
  logic               res_valid;
  logic               res_taken;

  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [bgrc_pkg::OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic                              out_tuser_r, out_tuser_nxt;

  // sequencer
  bgrc_seq #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_col    (in_tdata[4:0]),
    .in_row    (in_tdata[10:5]),
    .in_on     (in_tdata[11]),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_rdata (mem_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_taken (res_taken)
  );

  // cell grid
  bgrc_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_taken = res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (res_taken) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {2'b00, res.rows, res.cols, res.row, res.col};
      out_tuser_nxt  = res.found;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ===== design/bgrc_checker.sv =====
// bgrc_checker: port-level checks for the greedy rectangle cover core
// bound to bitmap_greedy_rectangle_cover_core; uses bgrc_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module bgrc_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_tvalid,
  input wire                                  in_tready,
  input wire                                  in_tuser,
  input wire                                  out_tvalid,
  input wire                                  out_tready,
  input wire [bgrc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input wire                                  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // not-found results carry all-zero fields
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero fields");

  // found rectangles have nonzero extent on both sides
  a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[15:11] != 5'd0) && (out_tdata[21:16] != 6'd0))
    else $error("found rectangle with zero extent");

  // clearing pass keeps the input closed straight after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during grid clearing");

  // a rectangle request closes the input for its work
  a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == bgrc_pkg::ACT_REQUEST) |=> !in_tready)
    else $error("input ready right after a rectangle request");

endmodule

bind bitmap_greedy_rectangle_cover_core bgrc_checker u_bgrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
